// ===== hdl/lsh_pkg.sv =====
// Shared types, constants and the sharpening kernel of the 3x3 Laplacian sharpening filter.
// Used by lsh_line_buffers and laplacian_sharpen_3x3_top; depends on nothing else.
package lsh_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int FW_W      = 11;
  localparam int ROW_W     = 16;
  localparam int OUT_COL_W = 10;
  localparam int PIX_W     = 8;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [FW_W-1:0]  FW_MIN   = FW_W'(3);
  localparam logic [FW_W-1:0]  FW_MAX   = FW_W'(MAX_WIDTH);
  localparam logic [FW_W-1:0]  FW_RESET = FW_W'(1024);
  localparam logic [ROW_W-1:0] FH_MIN   = ROW_W'(3);
  localparam logic [ROW_W-1:0] FH_RESET = ROW_W'(1024);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1
  } reg_index_t;

  typedef logic [PIX_W-1:0] pix_t;

  // One write into both line buffers at the same column.
  typedef struct packed {
    logic             en;
    logic [COL_W-1:0] addr;
    pix_t             newer;
    pix_t             older;
  } lb_write_t;

  // 5*centre minus the four direct neighbours, saturated to 0..255.
  function automatic pix_t sharpen(pix_t left, pix_t centre, pix_t right,
                                   pix_t up, pix_t down);
    logic [PIX_W+2:0] pos;
    logic [PIX_W+2:0] neg;
    logic [PIX_W+2:0] diff;
    pix_t             res;
    pos  = {1'b0, centre, 2'b00} + {3'b000, centre};
    neg  = {3'b000, left} + {3'b000, right} + {3'b000, up} + {3'b000, down};
    diff = pos - neg;
    if (pos < neg) begin
      res = '0;
    end else if (diff > (PIX_W+3)'(255)) begin
      res = '1;
    end else begin
      res = diff[PIX_W-1:0];
    end
    return res;
  endfunction

endpackage

// ===== hdl/lsh_line_buffers.sv =====
// Two row buffers of the sharpening filter: the row above and the row two above.
// Depends on lsh_pkg; at most one write and one registered read per buffer each cycle.
module lsh_line_buffers
  import lsh_pkg::*;
(
  input  logic             clk,
  input  logic             rd_en,
  input  logic [COL_W-1:0] rd_addr,
  input  lb_write_t        wr,
  output pix_t             rd_newer,
  output pix_t             rd_older
);

  pix_t newer_line [MAX_WIDTH];
  pix_t older_line [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      newer_line[wr.addr] <= wr.newer;
      older_line[wr.addr] <= wr.older;
    end
  end

  // Read data holds until the next read, so a stalled pixel keeps its column.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_newer <= newer_line[rd_addr];
      rd_older <= older_line[rd_addr];
    end
  end

endmodule

// ===== hdl/laplacian_sharpen_3x3_top.sv =====
// 3x3 Laplacian sharpening filter over a raster stream of 8-bit pixels.
// Accepted pixels wait in the work register; their results pass through the output register.
// Throughput: one pixel per cycle unless the output stalls; a pixel ending a row or on the
// last row is held until all its results are out (two, or four at the last row's end).
// Reset: position counters and window cleared, frame set to 1024 x 1024; the row
// buffers are not cleared, and their stale contents never reach a result.
module laplacian_sharpen_3x3_top
  import lsh_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [PIX_W-1:0]     pixel,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [ROW_W-1:0]     out_row,
  output logic [OUT_COL_W-1:0] out_col,
  output logic [PIX_W-1:0]     value,
  output logic                 run_last
);

  // Frame geometry, stored already clamped to the legal range.
  logic [FW_W-1:0]  frame_width;
  logic [ROW_W-1:0] frame_height;

  // Position of the next pixel request.
  logic [ROW_W-1:0] row_count;
  logic [COL_W-1:0] col_count;

  // The window: middle row at c-2 and c-1, upper row at c-1, lower row at c-1.
  pix_t win_left;
  pix_t win_centre;
  pix_t win_up;
  pix_t win_down;

  // Work register: the accepted pixel waiting for its results to be issued.
  logic             s1_valid;
  pix_t             s1_pixel;
  logic [ROW_W-1:0] s1_row;
  logic [COL_W-1:0] s1_col;
  logic [1:0]       s1_k;

  pix_t      mid_right;
  pix_t      top_right;
  lb_write_t lb_wr;

  logic             in_accept;
  logic             last_row;
  logic             last_col;
  logic             has_res;
  logic [1:0]       n_m1;
  logic             out_load;
  logic             s1_done;
  pix_t             kernel_val;
  logic [ROW_W-1:0] res_row;
  logic [COL_W-1:0] res_col;
  pix_t             res_val;
  logic [FW_W-1:0]  w_clamped;
  logic [ROW_W-1:0] h_clamped;
  logic             cfg_hit;

  assign in_accept = in_valid && in_ready;

  lsh_line_buffers u_lines (
    .clk      (clk),
    .rd_en    (in_accept),
    .rd_addr  (col_count),
    .wr       (lb_wr),
    .rd_newer (mid_right),
    .rd_older (top_right)
  );

  // Configuration writes clamp the value and restart the frame at row 0, column 0.
  always_comb begin
    w_clamped = cfg_data[FW_W-1:0];
    if (w_clamped < FW_MIN) begin
      w_clamped = FW_MIN;
    end else if (w_clamped > FW_MAX) begin
      w_clamped = FW_MAX;
    end
    h_clamped = cfg_data[ROW_W-1:0];
    if (h_clamped < FH_MIN) begin
      h_clamped = FH_MIN;
    end
    cfg_hit = cfg_write && (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FW_RESET;
      frame_height <= FH_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= w_clamped;
        REG_FRAME_HEIGHT: frame_height <= h_clamped;
        default:          ;
      endcase
    end
  end

  // Raster position of the next request, wrapping at row and frame ends.
  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      row_count <= '0;
      col_count <= '0;
    end else if (in_accept) begin
      if (FW_W'(col_count) + FW_W'(1) >= frame_width) begin
        col_count <= '0;
        if (ROW_W'(row_count + ROW_W'(1)) >= frame_height || row_count == '1) begin
          row_count <= '0;
        end else begin
          row_count <= row_count + ROW_W'(1);
        end
      end else begin
        col_count <= col_count + COL_W'(1);
      end
    end
  end

  // The result list of the held pixel. Pixels in row 0 or column 0 cause no
  // result. The first result is row r-1 at column c-1; on the last row the
  // border pixel of row r at column c-1 follows; a row end adds column c of
  // row r-1 and, on the last row, of row r as well.
  always_comb begin
    last_row   = (s1_row == frame_height - ROW_W'(1));
    last_col   = (FW_W'(s1_col) == frame_width - FW_W'(1));
    has_res    = (s1_row != '0) && (s1_col != '0);
    n_m1       = {last_col && last_row, last_col || last_row};
    kernel_val = sharpen(win_left, win_centre, mid_right, win_up, win_down);

    res_row = s1_row - ROW_W'(1);
    res_col = s1_col - COL_W'(1);
    res_val = '0;
    case (s1_k)
      2'd0: begin
        if (s1_row != ROW_W'(1) && s1_col != COL_W'(1)) begin
          res_val = kernel_val;
        end
      end
      2'd1: begin
        if (last_row) begin
          res_row = s1_row;
        end else begin
          res_col = s1_col;
        end
      end
      2'd2: begin
        res_col = s1_col;
      end
      2'd3: begin
        res_row = s1_row;
        res_col = s1_col;
      end
      default: ;
    endcase

    out_load = s1_valid && has_res && (!out_valid || out_ready);
    s1_done  = s1_valid && (!has_res || (out_load && s1_k == n_m1));
    in_ready = !s1_valid || s1_done;

    // When the held pixel retires it enters the row buffers at its column.
    lb_wr.en    = s1_done;
    lb_wr.addr  = s1_col;
    lb_wr.newer = s1_pixel;
    lb_wr.older = mid_right;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_k     <= '0;
    end else begin
      if (in_accept) begin
        s1_valid <= 1'b1;
      end else if (s1_done) begin
        s1_valid <= 1'b0;
      end
      if (out_load) begin
        s1_k <= (s1_k == n_m1) ? 2'd0 : s1_k + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_pixel <= pixel;
      s1_row   <= row_count;
      s1_col   <= col_count;
    end
  end

  // The window slides once per retired pixel.
  always_ff @(posedge clk) begin
    if (rst) begin
      win_left   <= '0;
      win_centre <= '0;
      win_up     <= '0;
      win_down   <= '0;
    end else if (s1_done) begin
      win_left   <= win_centre;
      win_centre <= mid_right;
      win_up     <= top_right;
      win_down   <= s1_pixel;
    end
  end

  // Output register: holds a result until its request is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_row  <= res_row;
      out_col  <= OUT_COL_W'(res_col);
      value    <= res_val;
      run_last <= (s1_k == n_m1);
    end
  end

endmodule
